FILE: src/linked_list_dma_walker_core_macros.svh
// Assertion helpers for the linked-list DMA walker.
`ifndef LINKED_LIST_DMA_WALKER_CORE_MACROS_SVH
`define LINKED_LIST_DMA_WALKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LLDW_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lldw assertion failed");
`define LLDW_ASSERT(lbl, prop) `LLDW_ASSERT_CLK(lbl, aclk, aresetn, prop)
`else
`define LLDW_ASSERT_CLK(lbl, clk, rstn, prop)
`define LLDW_ASSERT(lbl, prop)
`endif

`endif

FILE: src/lldw_pkg.sv
package lldw_pkg;

    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 32;
    localparam int LINK_W   = 24;
    localparam int COUNT_W  = 8;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [LINK_W-1:0] END_LINK       = {LINK_W{1'b1}};
    localparam logic [ADDR_W-1:0] WORD_BYTES     = 32'd4;
    localparam logic [DATA_W-1:0] NODE_LIMIT_RST = {DATA_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_REPLY  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ADDRESS = 1'b0,
        CFG_NODE_LIMIT    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [ADDR_W-1:0]   node_addr;
        logic [LINK_W-1:0]   next_link;
        logic [COUNT_W-1:0]  payload_count;
        logic [COUNT_W-1:0]  pay_idx;
        logic [DATA_W-1:0]   nodes_visited;
        logic [DATA_W-1:0]   word_total;
        logic                limit_flag;
    } walk_state_t;

    localparam walk_state_t WALK_CLEAR = '{
        phase:         PH_IDLE,
        node_addr:     '0,
        next_link:     '0,
        payload_count: '0,
        pay_idx:       '0,
        nodes_visited: '0,
        word_total:    '0,
        limit_flag:    1'b0
    };

    typedef struct packed {
        logic              req_valid;
        logic [ADDR_W-1:0] req_addr;
        logic              emit_valid;
        logic [ADDR_W-1:0] emit_addr;
        logic [DATA_W-1:0] emit_data;
        logic              done_res;
        logic              limit_reached;
        logic              busy_res;
        logic [DATA_W-1:0] words_read;
    } walk_result_t;

endpackage

FILE: src/lldw_step.sv
module lldw_step (
    input  lldw_pkg::walk_state_t            st,
    input  lldw_pkg::op_t                    opcode,
    input  logic [lldw_pkg::DATA_W-1:0]      read_data,
    input  logic [lldw_pkg::ADDR_W-1:0]      start_address,
    input  logic [lldw_pkg::DATA_W-1:0]      node_limit,
    output lldw_pkg::walk_state_t            st_next,
    output lldw_pkg::walk_result_t           res
);
    import lldw_pkg::*;

    logic                hdr_sel;
    logic [LINK_W-1:0]   fol_link;
    logic [DATA_W-1:0]   fol_visited;
    logic                fol_end;
    logic                fol_limit;
    logic [ADDR_W-1:0]   fol_addr;
    logic [ADDR_W-1:0]   pay_off;
    logic [ADDR_W-1:0]   pay_addr;
    logic [ADDR_W-1:0]   pay_next_addr;
    logic [COUNT_W-1:0]  pay_next_idx;
    logic [COUNT_W-1:0]  hdr_count;

    always_comb begin
        hdr_sel       = (st.phase == PH_HEADER);
        hdr_count     = read_data[DATA_W-1 -: COUNT_W];
        fol_link      = hdr_sel ? read_data[LINK_W-1:0] : st.next_link;
        fol_visited   = hdr_sel ? st.nodes_visited + 1'b1 : st.nodes_visited;
        fol_end       = (fol_link == END_LINK);
        fol_limit     = (fol_visited >= node_limit);
        fol_addr      = {{(ADDR_W-LINK_W){1'b0}}, fol_link};
        pay_off       = {{(ADDR_W-COUNT_W-2){1'b0}}, st.pay_idx, 2'b00};
        pay_addr      = st.node_addr + pay_off + WORD_BYTES;
        pay_next_addr = st.node_addr + pay_off + (WORD_BYTES << 1);
        pay_next_idx  = st.pay_idx + 1'b1;
    end

    always_comb begin
        st_next = st;
        res     = '0;
        unique case (opcode)
            OP_START: begin
                st_next           = WALK_CLEAR;
                st_next.node_addr = start_address;
                if (node_limit == '0) begin
                    st_next.limit_flag = 1'b1;
                    res.done_res       = 1'b1;
                end else begin
                    st_next.phase = PH_HEADER;
                    res.req_valid = 1'b1;
                    res.req_addr  = start_address;
                end
            end
            OP_CANCEL: begin
                st_next = WALK_CLEAR;
            end
            OP_REPLY: begin
                unique case (st.phase)
                    PH_IDLE: begin
                    end
                    PH_HEADER: begin
                        st_next.payload_count = hdr_count;
                        st_next.next_link     = read_data[LINK_W-1:0];
                        st_next.pay_idx       = '0;
                        st_next.nodes_visited = fol_visited;
                        st_next.word_total    = st.word_total + 1'b1;
                        if (hdr_count != '0) begin
                            st_next.phase = PH_PAYLOAD;
                            res.req_valid = 1'b1;
                            res.req_addr  = st.node_addr + WORD_BYTES;
                        end else if (fol_end) begin
                            st_next.phase = PH_IDLE;
                            res.done_res  = 1'b1;
                        end else begin
                            st_next.node_addr = fol_addr;
                            if (fol_limit) begin
                                st_next.limit_flag = 1'b1;
                                st_next.phase      = PH_IDLE;
                                res.done_res       = 1'b1;
                            end else begin
                                st_next.phase = PH_HEADER;
                                res.req_valid = 1'b1;
                                res.req_addr  = fol_addr;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        res.emit_valid     = 1'b1;
                        res.emit_addr      = pay_addr;
                        res.emit_data      = read_data;
                        st_next.pay_idx    = pay_next_idx;
                        st_next.word_total = st.word_total + 1'b1;
                        if (pay_next_idx < st.payload_count && pay_next_idx != '0) begin
                            res.req_valid = 1'b1;
                            res.req_addr  = pay_next_addr;
                        end else if (fol_end) begin
                            st_next.phase = PH_IDLE;
                            res.done_res  = 1'b1;
                        end else begin
                            st_next.node_addr = fol_addr;
                            if (fol_limit) begin
                                st_next.limit_flag = 1'b1;
                                st_next.phase      = PH_IDLE;
                                res.done_res       = 1'b1;
                            end else begin
                                st_next.phase = PH_HEADER;
                                res.req_valid = 1'b1;
                                res.req_addr  = fol_addr;
                            end
                        end
                    end
                    default: begin
                        st_next.limit_flag = 1'b1;
                        st_next.phase      = PH_IDLE;
                        res.done_res       = 1'b1;
                    end
                endcase
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
        res.limit_reached = st_next.limit_flag;
        res.busy_res      = (st_next.phase != PH_IDLE);
        res.words_read    = st_next.word_total;
    end

endmodule

FILE: src/linked_list_dma_walker_core.sv
// Linked-list DMA walker: each accepted item (start, memory reply, cancel or
// no-op) yields exactly one result item carrying the next read request, any
// payload word with its address, and the walk's done, limit and busy status.
// The block takes one item per clock as long as m_ready takes each result, and
// registers each item in the input register; the walk-state update then writes
// its result into the result register. A full result register does not block
// intake at once: the input register holds one more item while it waits.
module linked_list_dma_walker_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lldw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lldw_pkg::DATA_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lldw_pkg::OP_W-1:0]             s_opcode,
    input  logic [lldw_pkg::DATA_W-1:0]           s_read_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_req_valid,
    output logic [lldw_pkg::ADDR_W-1:0]           m_req_addr,
    output logic                                  m_emit_valid,
    output logic [lldw_pkg::ADDR_W-1:0]           m_emit_addr,
    output logic [lldw_pkg::DATA_W-1:0]           m_emit_data,
    output logic                                  m_done_res,
    output logic                                  m_limit_reached,
    output logic                                  m_busy_res,
    output logic [lldw_pkg::DATA_W-1:0]           m_words_read
);
    import lldw_pkg::*;

    `include "linked_list_dma_walker_core_macros.svh"

    logic [ADDR_W-1:0]  start_address_reg;
    logic [DATA_W-1:0]  node_limit_reg;

    logic               in_valid_reg;
    logic               in_valid_next;
    op_t                in_opcode_reg;
    logic [DATA_W-1:0]  in_data_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    walk_result_t       out_reg;

    walk_state_t        state_reg;
    walk_state_t        state_next;
    walk_result_t       step_res;

    logic               advance;
    logic               take_in;

    lldw_step u_step (
        .st            (state_reg),
        .opcode        (in_opcode_reg),
        .read_data     (in_data_reg),
        .start_address (start_address_reg),
        .node_limit    (node_limit_reg),
        .st_next       (state_next),
        .res           (step_res)
    );

    always_comb begin
        advance        = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready        = !in_valid_reg || advance;
        take_in        = s_valid && s_ready;
        in_valid_next  = take_in || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_address_reg <= '0;
            node_limit_reg    <= NODE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_START_ADDRESS: start_address_reg <= cfg_wdata;
                CFG_NODE_LIMIT:    node_limit_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= WALK_CLEAR;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_opcode_reg <= op_t'(s_opcode);
            in_data_reg   <= s_read_data;
        end
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_req_valid     = out_reg.req_valid;
    assign m_req_addr      = out_reg.req_addr;
    assign m_emit_valid    = out_reg.emit_valid;
    assign m_emit_addr     = out_reg.emit_addr;
    assign m_emit_data     = out_reg.emit_data;
    assign m_done_res      = out_reg.done_res;
    assign m_limit_reached = out_reg.limit_reached;
    assign m_busy_res      = out_reg.busy_res;
    assign m_words_read    = out_reg.words_read;

    `LLDW_ASSERT(a_done_not_busy, m_valid && m_done_res |-> !m_busy_res)
    `LLDW_ASSERT(a_req_busy, m_valid && m_req_valid |-> m_busy_res && !m_done_res)
    `LLDW_ASSERT(a_emit_moves_on, m_valid && m_emit_valid |-> m_req_valid || m_done_res)
    `LLDW_ASSERT(a_hold_pending, in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lldw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit           is_cfg;
        logic [31:0]  base;
        logic [31:0]  node_cap;
        op_t          op;
        logic [31:0]  data;
        bit           typed;
        walk_result_t want;
    } stim_row_t;

    localparam walk_result_t QUIET = '0;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode;
    logic [DATA_W-1:0]    s_read_data;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_req_valid;
    logic [ADDR_W-1:0]    m_req_addr;
    logic                 m_emit_valid;
    logic [ADDR_W-1:0]    m_emit_addr;
    logic [DATA_W-1:0]    m_emit_data;
    logic                 m_done_res;
    logic                 m_limit_reached;
    logic                 m_busy_res;
    logic [DATA_W-1:0]    m_words_read;

    linked_list_dma_walker_core dut (.*);

    always #5 aclk = ~aclk;

    // walk state mirror
    logic [31:0] cfg_base;
    logic [31:0] cfg_node_cap;
    phase_t      wk_phase;
    logic [31:0] wk_node;
    logic [23:0] wk_link;
    logic [7:0]  wk_cnt;
    logic [7:0]  wk_idx;
    logic [31:0] wk_nodes;
    logic [31:0] wk_words;
    logic        wk_limflag;

    walk_result_t pending_results[$];
    walk_result_t observed;
    walk_result_t want;
    stim_row_t    directed[$];
    int           mismatches = 0;
    int           cycles = 0;
    int           send_idle_pct;
    int           recv_idle_pct;

    function automatic void reset_walk();
        wk_phase   = PH_IDLE;
        wk_node    = '0;
        wk_link    = '0;
        wk_cnt     = '0;
        wk_idx     = '0;
        wk_nodes   = '0;
        wk_words   = '0;
        wk_limflag = 1'b0;
    endfunction

    function automatic void open_node(inout walk_result_t r);
        if (wk_nodes >= cfg_node_cap) begin
            wk_limflag = 1'b1;
            wk_phase   = PH_IDLE;
            r.done_res = 1'b1;
        end else begin
            wk_phase    = PH_HEADER;
            r.req_valid = 1'b1;
            r.req_addr  = wk_node;
        end
    endfunction

    function automatic void next_node(inout walk_result_t r);
        if (wk_link == END_LINK) begin
            wk_phase   = PH_IDLE;
            r.done_res = 1'b1;
        end else begin
            wk_node = {8'h00, wk_link};
            open_node(r);
        end
    endfunction

    function automatic walk_result_t walk_step(op_t op, logic [31:0] data);
        walk_result_t r;
        r = '0;
        case (op)
            OP_START: begin
                reset_walk();
                wk_node = cfg_base;
                open_node(r);
            end
            OP_CANCEL: reset_walk();
            OP_REPLY: begin
                if (wk_phase == PH_HEADER) begin
                    wk_cnt   = data[31:24];
                    wk_link  = data[23:0];
                    wk_idx   = '0;
                    wk_nodes = wk_nodes + 32'd1;
                    wk_words = wk_words + 32'd1;
                    if (wk_cnt != 8'd0) begin
                        wk_phase    = PH_PAYLOAD;
                        r.req_valid = 1'b1;
                        r.req_addr  = wk_node + WORD_BYTES;
                    end else begin
                        next_node(r);
                    end
                end else if (wk_phase == PH_PAYLOAD) begin
                    r.emit_valid = 1'b1;
                    r.emit_addr  = wk_node + WORD_BYTES + {wk_idx, 2'b00};
                    r.emit_data  = data;
                    wk_idx   = wk_idx + 8'd1;
                    wk_words = wk_words + 32'd1;
                    if (wk_idx < wk_cnt && wk_idx != 8'd0) begin
                        r.req_valid = 1'b1;
                        r.req_addr  = wk_node + WORD_BYTES + {wk_idx, 2'b00};
                    end else begin
                        next_node(r);
                    end
                end
            end
            default: ;
        endcase
        r.limit_reached = wk_limflag;
        r.busy_res      = (wk_phase != PH_IDLE);
        r.words_read    = wk_words;
        return r;
    endfunction

    function automatic walk_result_t result_of(logic rv, logic [31:0] ra, logic ev,
                                               logic [31:0] ea, logic [31:0] ed, logic dn,
                                               logic lm, logic bz, logic [31:0] wr);
        return {rv, ra, ev, ea, ed, dn, lm, bz, wr};
    endfunction

    function automatic stim_row_t cfg_row(logic [31:0] base, logic [31:0] node_cap);
        stim_row_t row;
        row = '{is_cfg: 1'b1, base: base, node_cap: node_cap, op: OP_NOP,
                data: '0, typed: 1'b0, want: QUIET};
        return row;
    endfunction

    function automatic stim_row_t op_row(op_t op, logic [31:0] data);
        stim_row_t row;
        row = '{is_cfg: 1'b0, base: '0, node_cap: '0, op: op,
                data: data, typed: 1'b0, want: QUIET};
        return row;
    endfunction

    function automatic stim_row_t op_want(op_t op, logic [31:0] data, walk_result_t w);
        stim_row_t row;
        row = '{is_cfg: 1'b0, base: '0, node_cap: '0, op: op,
                data: data, typed: 1'b1, want: w};
        return row;
    endfunction

    task automatic send_item(op_t op, logic [31:0] data, bit typed, walk_result_t w);
        walk_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_read_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = walk_step(op, data);
        pending_results.push_back(typed ? w : predicted);
    endtask

    task automatic program_walk(logic [31:0] base, logic [31:0] node_cap);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_ADDRESS;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_index <= CFG_NODE_LIMIT;
        cfg_wdata <= node_cap;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        cfg_base     = base;
        cfg_node_cap = node_cap;
        @(posedge aclk);
    endtask

    task automatic send_random_item();
        op_t         op;
        logic [31:0] d;
        logic [7:0]  count;
        logic [23:0] link;
        d     = $urandom;
        count = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 3));
        link  = ($urandom_range(0, 3) == 0) ? END_LINK : 24'($urandom);
        if ($urandom_range(0, 99) < 6) begin
            op = op_t'($urandom_range(0, 3));
        end else begin
            case (wk_phase)
                PH_HEADER: begin
                    op = OP_REPLY;
                    d  = {count, link};
                end
                PH_PAYLOAD: op = OP_REPLY;
                default: op = OP_START;
            endcase
        end
        send_item(op, d, 1'b0, QUIET);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("linked_list_dma_walker_core test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            observed = {m_req_valid, m_req_addr, m_emit_valid, m_emit_addr, m_emit_data,
                        m_done_res, m_limit_reached, m_busy_res, m_words_read};
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result item: req %0b/%h emit %0b/%h/%h done %0b",
                             observed.req_valid, observed.req_addr, observed.emit_valid,
                             observed.emit_addr, observed.emit_data, observed.done_res);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (observed !== want) begin
                    if (mismatches < 10) begin
                        $display("mismatch exp: req %0b/%h emit %0b/%h/%h d%0b l%0b b%0b w%h",
                                 want.req_valid, want.req_addr, want.emit_valid,
                                 want.emit_addr, want.emit_data, want.done_res,
                                 want.limit_reached, want.busy_res, want.words_read);
                        $display("         got: req %0b/%h emit %0b/%h/%h d%0b l%0b b%0b w%h",
                                 observed.req_valid, observed.req_addr, observed.emit_valid,
                                 observed.emit_addr, observed.emit_data, observed.done_res,
                                 observed.limit_reached, observed.busy_res,
                                 observed.words_read);
                    end
                    mismatches++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        logic [31:0] base;
        logic [31:0] node_cap;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_START_ADDRESS;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_opcode    <= OP_NOP;
        s_read_data <= '0;
        m_ready     <= 1'b0;
        cfg_base     = '0;
        cfg_node_cap = NODE_LIMIT_RST;
        reset_walk();
        send_idle_pct = 15;
        recv_idle_pct = 87;

        directed = '{
            op_want(OP_REPLY, 32'hFFFF_FFFF, QUIET),
            op_want(OP_NOP, 32'h0000_0000, QUIET),
            op_want(OP_START, 32'h0000_0000,
                    result_of(1'b1, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, 32'h0)),
            op_row(OP_REPLY, 32'h0200_0040),
            op_row(OP_REPLY, 32'hDEAD_BEEF),
            op_row(OP_REPLY, 32'h0000_0000),
            op_row(OP_REPLY, 32'h00FF_FFFF),
            op_row(OP_START, 32'h5A5A_5A5A),
            op_row(OP_REPLY, 32'h0000_0100),
            op_row(OP_START, 32'h0000_0000),
            op_row(OP_REPLY, 32'h0100_0010),
            op_want(OP_CANCEL, 32'hFFFF_FFFF, QUIET),
            cfg_row(32'hFFFF_FFF8, 32'h0000_0000),
            op_want(OP_START, 32'h0000_0000,
                    result_of(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0, 32'h0)),
            op_want(OP_REPLY, 32'h1234_5678,
                    result_of(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0, 32'h0)),
            op_want(OP_START, 32'hFFFF_FFFF,
                    result_of(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0, 32'h0)),
            cfg_row(32'hFFFF_FFF8, 32'h0000_0001),
            op_row(OP_START, 32'h0000_0000),
            op_row(OP_REPLY, 32'hFFFF_FFFF),
            op_row(OP_REPLY, 32'h1234_5678),
            op_want(OP_CANCEL, 32'h0000_0000, QUIET),
            op_row(OP_START, 32'h0000_0000),
            op_row(OP_REPLY, 32'h00AB_CDEF),
            op_row(OP_NOP, 32'hFFFF_FFFF),
            cfg_row(32'hFFFF_FFFF, 32'hFFFF_FFFF),
            op_want(OP_START, 32'h0000_0000,
                    result_of(1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1,
                              32'h0)),
            op_row(OP_REPLY, 32'h01FF_FFFF),
            op_row(OP_REPLY, 32'hA5A5_A5A5)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                program_walk(directed[i].base, directed[i].node_cap);
            else
                send_item(directed[i].op, directed[i].data, directed[i].typed,
                          directed[i].want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 87 : 0;
            recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 15 : 0;
            for (int b = 0; b < 4; b++) begin
                case ($urandom_range(0, 3))
                    0: base = 32'h0000_0000;
                    1: base = 32'hFFFF_FFFC;
                    default: base = $urandom;
                endcase
                case ($urandom_range(0, 6))
                    0: node_cap = 32'h0000_0000;
                    1: node_cap = 32'h0000_0001;
                    2, 3: node_cap = $urandom_range(2, 6);
                    4: node_cap = 32'hFFFF_FFFF;
                    5: node_cap = 32'hFFFF_FFFE;
                    default: node_cap = $urandom;
                endcase
                program_walk(base, node_cap);
                repeat (110) send_random_item();
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("linked_list_dma_walker_core test passed");
        else
            $display("linked_list_dma_walker_core test failed");
        $finish;
    end

endmodule
